FILE: hw/rtl/complex_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// complex arithmetic unit assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("complex arithmetic unit assertion failed");

// next-cycle implication
`define CAU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("complex arithmetic unit assertion failed");

`endif

FILE: hw/rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// types, codes and helpers shared by the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned SUM_W  = 65;
    localparam int unsigned DEN_W  = 64;
    localparam int unsigned Q_W    = 32;
    localparam int unsigned REM_W  = DEN_W + Q_W;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4,
        OP_NEG  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } t_sat;

    // control and finished non-divide results travelling with each transaction
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              div0;
        logic              neg_re;
        logic              neg_im;
        logic              big_re;
        logic              big_im;
        logic [DATA_W-1:0] res_re;
        logic [DATA_W-1:0] res_im;
        t_status           status;
    } t_ctl;

    function automatic t_sat sat_wide(input logic signed [SUM_W-1:0] x);
        t_sat r;
        r.ovf = !((&x[SUM_W-1:DATA_W-1]) || !(|x[SUM_W-1:DATA_W-1]));
        if (r.ovf) begin
            r.val = x[SUM_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            r.val = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// four stages: products, sums, saturation and divider set-up, range check
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [2:0]                   i_op,
    input  logic signed [31:0]           i_a_re,
    input  logic signed [31:0]           i_a_im,
    input  logic signed [31:0]           i_b_re,
    input  logic signed [31:0]           i_b_im,
    output cau_pkg::t_ctl                o_ctl,
    output logic [cau_pkg::REM_W-1:0]    o_rem_re,
    output logic [cau_pkg::REM_W-1:0]    o_rem_im,
    output logic [cau_pkg::DEN_W-1:0]    o_den
);
    import cau_pkg::*;

    // stage 1
    logic                     r_s1_valid;
    t_op                      r_s1_op;
    logic                     r_s1_div0;
    logic signed [PROD_W-1:0] r_s1_p_rr, r_s1_p_ii, r_s1_p_ri, r_s1_p_ir;
    logic signed [PROD_W-1:0] r_s1_p_bb, r_s1_p_b2;
    logic signed [DATA_W:0]   r_s1_s_re, r_s1_s_im;
    logic signed [DATA_W:0]   n_s1_s_re, n_s1_s_im;

    // stage 2
    logic                     r_s2_valid;
    t_op                      r_s2_op;
    logic                     r_s2_div0;
    logic signed [DATA_W:0]   r_s2_s_re, r_s2_s_im;
    logic signed [SUM_W-1:0]  r_s2_m_re, r_s2_m_im, r_s2_n_re, r_s2_n_im;
    logic [DEN_W-1:0]         r_s2_den;
    logic signed [SUM_W-1:0]  w_mdiff, w_msum;

    // stage 3
    t_ctl                     r_s3_ctl, n_s3_ctl;
    logic [REM_W-1:0]         r_s3_mag_re, r_s3_mag_im;
    logic [DEN_W-1:0]         r_s3_den;
    logic [SUM_W-1:0]         w_abs_re, w_abs_im;
    t_sat                     w_sat_re, w_sat_im;

    // stage 4
    t_ctl                     r_s4_ctl, n_s4_ctl;
    logic [REM_W-1:0]         r_s4_mag_re, r_s4_mag_im;
    logic [DEN_W-1:0]         r_s4_den;
    logic [REM_W-1:0]         w_limit;

    always_comb begin
        n_s1_s_re = '0;
        n_s1_s_im = '0;
        case (t_op'(i_op))
            OP_ADD: begin
                n_s1_s_re = (DATA_W+1)'(i_a_re) + (DATA_W+1)'(i_b_re);
                n_s1_s_im = (DATA_W+1)'(i_a_im) + (DATA_W+1)'(i_b_im);
            end
            OP_SUB: begin
                n_s1_s_re = (DATA_W+1)'(i_a_re) - (DATA_W+1)'(i_b_re);
                n_s1_s_im = (DATA_W+1)'(i_a_im) - (DATA_W+1)'(i_b_im);
            end
            OP_CONJ: begin
                n_s1_s_re = (DATA_W+1)'(i_a_re);
                n_s1_s_im = -(DATA_W+1)'(i_a_im);
            end
            OP_NEG: begin
                n_s1_s_re = -(DATA_W+1)'(i_a_re);
                n_s1_s_im = -(DATA_W+1)'(i_a_im);
            end
            default: begin
                n_s1_s_re = '0;
                n_s1_s_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
        if (i_en) begin
            r_s1_op   <= t_op'(i_op);
            r_s1_div0 <= (i_b_re == '0) && (i_b_im == '0);
            r_s1_p_rr <= i_a_re * i_b_re;
            r_s1_p_ii <= i_a_im * i_b_im;
            r_s1_p_ri <= i_a_re * i_b_im;
            r_s1_p_ir <= i_a_im * i_b_re;
            r_s1_p_bb <= i_b_re * i_b_re;
            r_s1_p_b2 <= i_b_im * i_b_im;
            r_s1_s_re <= n_s1_s_re;
            r_s1_s_im <= n_s1_s_im;
        end
    end

    assign w_mdiff = SUM_W'(r_s1_p_rr) - SUM_W'(r_s1_p_ii);
    assign w_msum  = SUM_W'(r_s1_p_ri) + SUM_W'(r_s1_p_ir);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
        if (i_en) begin
            r_s2_op   <= r_s1_op;
            r_s2_div0 <= r_s1_div0;
            r_s2_s_re <= r_s1_s_re;
            r_s2_s_im <= r_s1_s_im;
            // floor shift of the full product sums
            r_s2_m_re <= w_mdiff >>> FRAC_BITS;
            r_s2_m_im <= w_msum >>> FRAC_BITS;
            r_s2_n_re <= SUM_W'(r_s1_p_rr) + SUM_W'(r_s1_p_ii);
            r_s2_n_im <= SUM_W'(r_s1_p_ir) - SUM_W'(r_s1_p_ri);
            r_s2_den  <= $unsigned(r_s1_p_bb) + $unsigned(r_s1_p_b2);
        end
    end

    assign w_abs_re = r_s2_n_re[SUM_W-1] ? SUM_W'(-r_s2_n_re) : SUM_W'(r_s2_n_re);
    assign w_abs_im = r_s2_n_im[SUM_W-1] ? SUM_W'(-r_s2_n_im) : SUM_W'(r_s2_n_im);

    always_comb begin
        if (r_s2_op == OP_MUL) begin
            w_sat_re = sat_wide(r_s2_m_re);
            w_sat_im = sat_wide(r_s2_m_im);
        end else begin
            w_sat_re = sat_wide(SUM_W'(r_s2_s_re));
            w_sat_im = sat_wide(SUM_W'(r_s2_s_im));
        end
        n_s3_ctl        = '0;
        n_s3_ctl.valid  = r_s2_valid;
        n_s3_ctl.is_div = (r_s2_op == OP_DIV);
        n_s3_ctl.div0   = r_s2_div0;
        n_s3_ctl.neg_re = r_s2_n_re[SUM_W-1];
        n_s3_ctl.neg_im = r_s2_n_im[SUM_W-1];
        n_s3_ctl.res_re = w_sat_re.val;
        n_s3_ctl.res_im = w_sat_im.val;
        n_s3_ctl.status = (w_sat_re.ovf || w_sat_im.ovf) ? ST_OVF : ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_s3_ctl.valid <= n_s3_ctl.valid;
        end
        if (i_en) begin
            r_s3_ctl.is_div <= n_s3_ctl.is_div;
            r_s3_ctl.div0   <= n_s3_ctl.div0;
            r_s3_ctl.neg_re <= n_s3_ctl.neg_re;
            r_s3_ctl.neg_im <= n_s3_ctl.neg_im;
            r_s3_ctl.big_re <= n_s3_ctl.big_re;
            r_s3_ctl.big_im <= n_s3_ctl.big_im;
            r_s3_ctl.res_re <= n_s3_ctl.res_re;
            r_s3_ctl.res_im <= n_s3_ctl.res_im;
            r_s3_ctl.status <= n_s3_ctl.status;
            r_s3_mag_re     <= REM_W'(w_abs_re) << FRAC_BITS;
            r_s3_mag_im     <= REM_W'(w_abs_im) << FRAC_BITS;
            r_s3_den        <= r_s2_den;
        end
    end

    // quotient of 2^32 or more saturates whatever its sign
    assign w_limit = {r_s3_den, {Q_W{1'b0}}};

    always_comb begin
        n_s4_ctl        = r_s3_ctl;
        n_s4_ctl.big_re = (r_s3_mag_re >= w_limit);
        n_s4_ctl.big_im = (r_s3_mag_im >= w_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_s4_ctl.valid <= n_s4_ctl.valid;
        end
        if (i_en) begin
            r_s4_ctl.is_div <= n_s4_ctl.is_div;
            r_s4_ctl.div0   <= n_s4_ctl.div0;
            r_s4_ctl.neg_re <= n_s4_ctl.neg_re;
            r_s4_ctl.neg_im <= n_s4_ctl.neg_im;
            r_s4_ctl.big_re <= n_s4_ctl.big_re;
            r_s4_ctl.big_im <= n_s4_ctl.big_im;
            r_s4_ctl.res_re <= n_s4_ctl.res_re;
            r_s4_ctl.res_im <= n_s4_ctl.res_im;
            r_s4_ctl.status <= n_s4_ctl.status;
            r_s4_mag_re     <= r_s3_mag_re;
            r_s4_mag_im     <= r_s3_mag_im;
            r_s4_den        <= r_s3_den;
        end
    end

    assign o_ctl    = r_s4_ctl;
    assign o_rem_re = r_s4_mag_re;
    assign o_rem_im = r_s4_mag_im;
    assign o_den    = r_s4_den;

endmodule

FILE: hw/rtl/cau_div_stage.sv
// ----------------------------------------------------------------------------
// cau_div_stage
// one registered restoring-division step for both quotient parts
// ----------------------------------------------------------------------------
module cau_div_stage #(
    parameter int SHIFT = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  cau_pkg::t_ctl             i_ctl,
    input  logic [cau_pkg::REM_W-1:0] i_rem_re,
    input  logic [cau_pkg::REM_W-1:0] i_rem_im,
    input  logic [cau_pkg::DEN_W-1:0] i_den,
    input  logic [cau_pkg::Q_W-1:0]   i_q_re,
    input  logic [cau_pkg::Q_W-1:0]   i_q_im,
    output cau_pkg::t_ctl             o_ctl,
    output logic [cau_pkg::REM_W-1:0] o_rem_re,
    output logic [cau_pkg::REM_W-1:0] o_rem_im,
    output logic [cau_pkg::DEN_W-1:0] o_den,
    output logic [cau_pkg::Q_W-1:0]   o_q_re,
    output logic [cau_pkg::Q_W-1:0]   o_q_im
);
    import cau_pkg::*;

    t_ctl             r_ctl;
    logic [REM_W-1:0] r_rem_re, r_rem_im;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_q_re, r_q_im;
    logic [Q_W-1:0]   n_q_re, n_q_im;
    logic [REM_W-1:0] w_dsh;
    logic             w_take_re, w_take_im;

    assign w_dsh     = REM_W'(i_den) << SHIFT;
    assign w_take_re = (i_rem_re >= w_dsh);
    assign w_take_im = (i_rem_im >= w_dsh);

    always_comb begin
        n_q_re        = i_q_re;
        n_q_im        = i_q_im;
        n_q_re[SHIFT] = w_take_re;
        n_q_im[SHIFT] = w_take_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.is_div <= i_ctl.is_div;
            r_ctl.div0   <= i_ctl.div0;
            r_ctl.neg_re <= i_ctl.neg_re;
            r_ctl.neg_im <= i_ctl.neg_im;
            r_ctl.big_re <= i_ctl.big_re;
            r_ctl.big_im <= i_ctl.big_im;
            r_ctl.res_re <= i_ctl.res_re;
            r_ctl.res_im <= i_ctl.res_im;
            r_ctl.status <= i_ctl.status;
            r_rem_re     <= w_take_re ? (i_rem_re - w_dsh) : i_rem_re;
            r_rem_im     <= w_take_im ? (i_rem_im - w_dsh) : i_rem_im;
            r_den        <= i_den;
            r_q_re       <= n_q_re;
            r_q_im       <= n_q_im;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_den    = r_den;
    assign o_q_re   = r_q_re;
    assign o_q_im   = r_q_im;

endmodule

FILE: hw/rtl/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// quotient sign and saturation, status merge, output register
// ----------------------------------------------------------------------------
module cau_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  cau_pkg::t_ctl              i_ctl,
    input  logic [cau_pkg::Q_W-1:0]    i_q_re,
    input  logic [cau_pkg::Q_W-1:0]    i_q_im,
    output logic                       o_valid,
    output logic [cau_pkg::DATA_W-1:0] o_res_re,
    output logic [cau_pkg::DATA_W-1:0] o_res_im,
    output cau_pkg::t_status           o_status
);
    import cau_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_res_re, r_res_im;
    t_status           r_status;
    logic [DATA_W-1:0] n_res_re, n_res_im;
    t_status           n_status;
    t_sat              w_fq_re, w_fq_im;

    function automatic t_sat fix_quot(input logic [Q_W-1:0] q, input logic neg,
                                      input logic big);
        t_sat r;
        r.ovf = 1'b0;
        r.val = q;
        if (big) begin
            r.ovf = 1'b1;
            r.val = neg ? SAT_MIN : SAT_MAX;
        end else if (!neg) begin
            if (q[Q_W-1]) begin
                r.ovf = 1'b1;
                r.val = SAT_MAX;
            end
        end else if (q > SAT_MIN) begin
            r.ovf = 1'b1;
            r.val = SAT_MIN;
        end else begin
            r.val = -q;
        end
        return r;
    endfunction

    assign w_fq_re = fix_quot(i_q_re, i_ctl.neg_re, i_ctl.big_re);
    assign w_fq_im = fix_quot(i_q_im, i_ctl.neg_im, i_ctl.big_im);

    always_comb begin
        if (!i_ctl.is_div) begin
            n_res_re = i_ctl.res_re;
            n_res_im = i_ctl.res_im;
            n_status = i_ctl.status;
        end else if (i_ctl.div0) begin
            n_res_re = '0;
            n_res_im = '0;
            n_status = ST_DIV0;
        end else begin
            n_res_re = w_fq_re.val;
            n_res_im = w_fq_im.val;
            n_status = (w_fq_re.ovf || w_fq_im.ovf) ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_res_re <= n_res_re;
            r_res_im <= n_res_im;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_res_re = r_res_re;
    assign o_res_im = r_res_im;
    assign o_status = r_status;

endmodule

FILE: hw/rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Q16.16 complex add, subtract, multiply, divide, conjugate and negate
// ----------------------------------------------------------------------------
// Takes one transaction per cycle and returns one result per transaction, in
// order. The pipeline has 37 register stages: four front stages (products,
// sums, saturation and divider set-up, quotient range check), 32
// restoring-division stages that each settle one quotient bit of both parts,
// and the output register. Every operation walks the full pipeline. When a
// finished result is not taken the whole pipeline holds, and tready drops.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [2:0]   i_s_tuser,   // operation
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,   // res_re, res_im
    output logic [1:0]   o_m_tuser    // status
);
    import cau_pkg::*;

    `include "complex_arithmetic_unit_assert.svh"

    logic             w_en;
    t_ctl             w_ctl    [0:Q_W];
    logic [REM_W-1:0] w_rem_re [0:Q_W];
    logic [REM_W-1:0] w_rem_im [0:Q_W];
    logic [DEN_W-1:0] w_den    [0:Q_W];
    logic [Q_W-1:0]   w_q_re   [0:Q_W];
    logic [Q_W-1:0]   w_q_im   [0:Q_W];
    logic [DATA_W-1:0] w_res_re, w_res_im;
    t_status           w_status;
    logic              w_clamped;

    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    cau_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_s_tvalid),
        .i_op     (i_s_tuser),
        .i_a_re   (i_s_tdata[31:0]),
        .i_a_im   (i_s_tdata[63:32]),
        .i_b_re   (i_s_tdata[95:64]),
        .i_b_im   (i_s_tdata[127:96]),
        .o_ctl    (w_ctl[0]),
        .o_rem_re (w_rem_re[0]),
        .o_rem_im (w_rem_im[0]),
        .o_den    (w_den[0])
    );

    assign w_q_re[0] = '0;
    assign w_q_im[0] = '0;

    for (genvar g = 0; g < Q_W; g++) begin : g_div
        cau_div_stage #(
            .SHIFT(Q_W - 1 - g)
        ) u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_ctl    (w_ctl[g]),
            .i_rem_re (w_rem_re[g]),
            .i_rem_im (w_rem_im[g]),
            .i_den    (w_den[g]),
            .i_q_re   (w_q_re[g]),
            .i_q_im   (w_q_im[g]),
            .o_ctl    (w_ctl[g+1]),
            .o_rem_re (w_rem_re[g+1]),
            .o_rem_im (w_rem_im[g+1]),
            .o_den    (w_den[g+1]),
            .o_q_re   (w_q_re[g+1]),
            .o_q_im   (w_q_im[g+1])
        );
    end

    cau_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (w_ctl[Q_W]),
        .i_q_re   (w_q_re[Q_W]),
        .i_q_im   (w_q_im[Q_W]),
        .o_valid  (o_m_tvalid),
        .o_res_re (w_res_re),
        .o_res_im (w_res_im),
        .o_status (w_status)
    );

    assign o_m_tdata = {w_res_im, w_res_re};
    assign o_m_tuser = w_status;

    assign w_clamped = (w_res_re == SAT_MAX) || (w_res_re == SAT_MIN)
                    || (w_res_im == SAT_MAX) || (w_res_im == SAT_MIN);

    // divide by zero always returns zero
    `CAU_ASSERT_IMP(a_div0_zero, o_m_tvalid && (o_m_tuser == ST_DIV0), o_m_tdata == '0)
    // an overflow status comes with at least one clamped part
    `CAU_ASSERT_IMP(a_ovf_clamped, o_m_tvalid && (o_m_tuser == ST_OVF), w_clamped)
    // a stall only freezes a result that is still pending
    `CAU_ASSERT_NXT(a_stall_pending, !w_en, o_m_tvalid)

endmodule
